@@ rtl/ecal_pkg.sv @@
`default_nettype none

package ecal_pkg;

   // field widths
   localparam int unsigned CountWidth  = 32;
   localparam int unsigned YearWidth   = 12;
   localparam int unsigned MonthWidth  = 4;
   localparam int unsigned DayWidth    = 5;
   localparam int unsigned HourWidth   = 5;
   localparam int unsigned MinuteWidth = 6;
   localparam int unsigned SecondWidth = 6;

   // internal widths
   localparam int unsigned DaysWidth   = 16;   // whole days, up to 49710
   localparam int unsigned RemWidth    = 17;   // seconds within the day
   localparam int unsigned YoffWidth   = 8;    // years since the epoch year
   localparam int unsigned DoyWidth    = 9;    // day of year, from 0
   localparam int unsigned MsWidth     = 12;   // seconds within the hour

   localparam int unsigned EpochYear   = 1970;
   localparam int unsigned YearCount   = 138;  // start days of 1970 .. 2107

   // seconds per day is 128 * 675; floor(2^34 / 675)
   localparam int unsigned DayShift    = 7;
   localparam int unsigned DayOdd      = 675;
   localparam int unsigned DayRecip    = 25451658;
   // ceil(2^30 / 1461) for the four-year estimate
   localparam int unsigned YearRecip   = 734937;
   // ceil(2^29 / 3600) and ceil(2^18 / 60)
   localparam int unsigned HourRecip   = 149131;
   localparam int unsigned SecsPerHour = 3600;
   localparam int unsigned MinRecip    = 4370;
   localparam int unsigned SecsPerMin  = 60;

   typedef logic [DaysWidth-1:0] ystart_tbl_type [YearCount];
   typedef logic [YearCount-1:0] leap_tbl_type;

   function automatic logic is_leap(input int unsigned y);
      logic leap;
      if (y % 400 == 0)      leap = 1'b1;
      else if (y % 100 == 0) leap = 1'b0;
      else                   leap = (y % 4 == 0);
      return leap;
   endfunction

   // first day of each year, counted from the epoch
   function automatic ystart_tbl_type build_ystart();
      ystart_tbl_type tbl;
      int unsigned    acc;
      acc = 0;
      for (int i = 0; i < YearCount; i++) begin
         tbl[i] = DaysWidth'(acc);
         acc    = acc + (is_leap(EpochYear + i) ? 366 : 365);
      end
      return tbl;
   endfunction

   function automatic leap_tbl_type build_leap();
      leap_tbl_type tbl;
      for (int i = 0; i < YearCount; i++) begin
         tbl[i] = is_leap(EpochYear + i);
      end
      return tbl;
   endfunction

   localparam ystart_tbl_type YearStart = build_ystart();
   localparam leap_tbl_type   LeapYears = build_leap();

   // day of year on which a month starts, month index from 0
   function automatic logic [DoyWidth-1:0] month_start(input logic [MonthWidth-1:0] idx,
                                                       input logic leap);
      logic [DoyWidth-1:0] base;
      case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && idx >= 4'd2) base = base + 9'd1;
      return base;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ecal_day_div.sv @@
`default_nettype none

module ecal_day_div
   import ecal_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [CountWidth-1:0] count,
   output logic      [DaysWidth-1:0]  days,
   output logic      [RemWidth-1:0]   rem
);

   localparam int unsigned XWidth = CountWidth - DayShift;
   localparam int unsigned PWidth = 2 * XWidth;

   logic [XWidth-1:0]    x_in;
   logic [PWidth-1:0]    prod_in;
   logic [DaysWidth-1:0] q1_ff;
   logic [XWidth-1:0]    x1_ff;
   logic [DayShift-1:0]  low1_ff;

   logic [XWidth:0]      r_wide_in;
   logic [10:0]          r2_ff;
   logic [DaysWidth-1:0] q2_ff;
   logic [DayShift-1:0]  low2_ff;

   logic [10:0]          r_in;
   logic [DaysWidth-1:0] days_in;
   logic [DaysWidth-1:0] days_ff;
   logic [RemWidth-1:0]  rem_ff;

   // stage 1: quotient estimate by reciprocal, low by one at most
   assign x_in    = count[CountWidth-1:DayShift];
   assign prod_in = PWidth'(x_in) * PWidth'(DayRecip);

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff   <= prod_in[PWidth-1 -: DaysWidth];
         x1_ff   <= x_in;
         low1_ff <= count[DayShift-1:0];
      end
   end

   // stage 2: partial remainder, below twice the divisor
   assign r_wide_in = (XWidth+1)'(x1_ff) - (XWidth+1)'(q1_ff) * (XWidth+1)'(DayOdd);

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff   <= r_wide_in[10:0];
         q2_ff   <= q1_ff;
         low2_ff <= low1_ff;
      end
   end

   // stage 3: one correction step
   always_comb begin
      if (r2_ff >= 11'(DayOdd)) begin
         days_in = q2_ff + 16'd1;
         r_in    = r2_ff - 11'(DayOdd);
      end else begin
         days_in = q2_ff;
         r_in    = r2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         days_ff <= days_in;
         rem_ff  <= {r_in[9:0], low2_ff};
      end
   end

   assign days = days_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

@@ rtl/ecal_date.sv @@
`default_nettype none

module ecal_date
   import ecal_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [DaysWidth-1:0]  days,
   output logic      [YearWidth-1:0]  year,
   output logic      [MonthWidth-1:0] month,
   output logic      [DayWidth-1:0]   day
);

   localparam int unsigned NumWidth  = DaysWidth + 2;
   localparam int unsigned ProdWidth = NumWidth + 20;

   logic [DaysWidth-1:0]  dp_in;
   logic [ProdWidth-1:0]  prod_in;
   logic [YoffWidth-1:0]  yest_in;
   logic [YoffWidth-1:0]  yest4_ff;
   logic [DaysWidth-1:0]  days4_ff;

   logic [YoffWidth-1:0]  ynext_in;
   logic [DaysWidth-1:0]  snext_in;
   logic [YoffWidth-1:0]  y_in;
   logic [DaysWidth-1:0]  ys_in;
   logic [YoffWidth-1:0]  y5_ff;
   logic [DaysWidth-1:0]  ys5_ff;
   logic [DaysWidth-1:0]  days5_ff;

   logic [DaysWidth-1:0]  doy_wide_in;
   logic [DoyWidth-1:0]   doy6_ff;
   logic                  leap6_ff;
   logic [YoffWidth-1:0]  y6_ff;

   logic [MonthWidth-1:0] midx_in;
   logic [MonthWidth-1:0] m7_ff;
   logic [DoyWidth-1:0]   doy7_ff;
   logic                  leap7_ff;
   logic [YoffWidth-1:0]  y7_ff;

   logic [DoyWidth-1:0]   dom_in;
   logic [YearWidth-1:0]  year_ff;
   logic [MonthWidth-1:0] month_ff;
   logic [DayWidth-1:0]   day_ff;

   // stage 4: year estimate as if every fourth year were leap
   assign dp_in   = days + DaysWidth'(365);
   assign prod_in = ProdWidth'({dp_in, 2'b11}) * ProdWidth'(YearRecip);
   assign yest_in = prod_in[ProdWidth-1 -: YoffWidth] - YoffWidth'(1);

   always_ff @(posedge clock) begin
      if (en) begin
         yest4_ff <= yest_in;
         days4_ff <= days;
      end
   end

   // stage 5: estimate falls short by one year after the skipped leap day
   assign ynext_in = yest4_ff + YoffWidth'(1);
   assign snext_in = YearStart[ynext_in];

   always_comb begin
      if (days4_ff >= snext_in) begin
         y_in  = ynext_in;
         ys_in = snext_in;
      end else begin
         y_in  = yest4_ff;
         ys_in = YearStart[yest4_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y5_ff    <= y_in;
         ys5_ff   <= ys_in;
         days5_ff <= days4_ff;
      end
   end

   // stage 6: day of year and leap flag
   assign doy_wide_in = days5_ff - ys5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         doy6_ff  <= doy_wide_in[DoyWidth-1:0];
         leap6_ff <= LeapYears[y5_ff];
         y6_ff    <= y5_ff;
      end
   end

   // stage 7: month index from parallel compares against month starts
   always_comb begin
      midx_in = '0;
      for (int i = 1; i < 12; i++) begin
         midx_in = midx_in + MonthWidth'(doy6_ff >= month_start(MonthWidth'(i), leap6_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m7_ff    <= midx_in;
         doy7_ff  <= doy6_ff;
         leap7_ff <= leap6_ff;
         y7_ff    <= y6_ff;
      end
   end

   // stage 8: day of month and output register
   assign dom_in = doy7_ff - month_start(m7_ff, leap7_ff) + DoyWidth'(1);

   always_ff @(posedge clock) begin
      if (en) begin
         year_ff  <= YearWidth'(EpochYear) + YearWidth'(y7_ff);
         month_ff <= m7_ff + MonthWidth'(1);
         day_ff   <= dom_in[DayWidth-1:0];
      end
   end

   assign year  = year_ff;
   assign month = month_ff;
   assign day   = day_ff;

endmodule

`default_nettype wire

@@ rtl/ecal_clock.sv @@
`default_nettype none

module ecal_clock
   import ecal_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic [RemWidth-1:0]    rem,
   output logic      [HourWidth-1:0]   hour,
   output logic      [MinuteWidth-1:0] minute,
   output logic      [SecondWidth-1:0] second
);

   localparam int unsigned HProdWidth = RemWidth + 18;
   localparam int unsigned MProdWidth = MsWidth + 13;

   logic [HProdWidth-1:0]  hprod_in;
   logic [HourWidth-1:0]   hour4_ff;
   logic [RemWidth-1:0]    rem4_ff;

   logic [RemWidth-1:0]    ms_wide_in;
   logic [MsWidth-1:0]     ms5_ff;
   logic [HourWidth-1:0]   hour5_ff;

   logic [MProdWidth-1:0]  mprod_in;
   logic [MinuteWidth-1:0] min6_ff;
   logic [MsWidth-1:0]     ms6_ff;
   logic [HourWidth-1:0]   hour6_ff;

   logic [MsWidth-1:0]     sec_wide_in;
   logic [SecondWidth-1:0] sec7_ff;
   logic [MinuteWidth-1:0] min7_ff;
   logic [HourWidth-1:0]   hour7_ff;

   logic [HourWidth-1:0]   hour_ff;
   logic [MinuteWidth-1:0] minute_ff;
   logic [SecondWidth-1:0] second_ff;

   // stage 4: hour by reciprocal, exact over one day
   assign hprod_in = HProdWidth'(rem) * HProdWidth'(HourRecip);

   always_ff @(posedge clock) begin
      if (en) begin
         hour4_ff <= hprod_in[29 +: HourWidth];
         rem4_ff  <= rem;
      end
   end

   // stage 5: seconds within the hour
   assign ms_wide_in = rem4_ff - RemWidth'(hour4_ff) * RemWidth'(SecsPerHour);

   always_ff @(posedge clock) begin
      if (en) begin
         ms5_ff   <= ms_wide_in[MsWidth-1:0];
         hour5_ff <= hour4_ff;
      end
   end

   // stage 6: minute by reciprocal, exact over one hour
   assign mprod_in = MProdWidth'(ms5_ff) * MProdWidth'(MinRecip);

   always_ff @(posedge clock) begin
      if (en) begin
         min6_ff  <= mprod_in[18 +: MinuteWidth];
         ms6_ff   <= ms5_ff;
         hour6_ff <= hour5_ff;
      end
   end

   // stage 7: seconds within the minute
   assign sec_wide_in = ms6_ff - MsWidth'(min6_ff) * MsWidth'(SecsPerMin);

   always_ff @(posedge clock) begin
      if (en) begin
         sec7_ff  <= sec_wide_in[SecondWidth-1:0];
         min7_ff  <= min6_ff;
         hour7_ff <= hour6_ff;
      end
   end

   // stage 8: output register, aligned with the date path
   always_ff @(posedge clock) begin
      if (en) begin
         hour_ff   <= hour7_ff;
         minute_ff <= min7_ff;
         second_ff <= sec7_ff;
      end
   end

   assign hour   = hour_ff;
   assign minute = minute_ff;
   assign second = second_ff;

endmodule

`default_nettype wire

@@ rtl/epoch_seconds_to_calendar.sv @@
// throughput: one item per cycle; the 8-stage pipeline advances as a whole,
//   so a result held on rsp stalls every stage and the req side with it
// reset: synchronous, active high; clears the stage valid bits only,
//   the datapath registers carry no reset
`default_nettype none

module epoch_seconds_to_calendar
   import ecal_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // seconds_count[31:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // year[11:0], month[15:12], day[20:16],
                                         // hour[25:21], minute[31:26], second[37:32]
);

   localparam int unsigned Stages = 8;

   logic [Stages-1:0]      valid_ff;
   logic                   en;
   logic [DaysWidth-1:0]   days;
   logic [RemWidth-1:0]    rem;
   logic [YearWidth-1:0]   year;
   logic [MonthWidth-1:0]  month;
   logic [DayWidth-1:0]    day;
   logic [HourWidth-1:0]   hour;
   logic [MinuteWidth-1:0] minute;
   logic [SecondWidth-1:0] second;

   // whole pipeline moves unless a finished item is waiting
   assign en = rsp_tready | ~valid_ff[Stages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[Stages-2:0], req_tvalid};
      end
   end

   // stages 1 to 3: split into whole days and seconds of the day
   ecal_day_div u_day_div (
      .clock (clock),
      .en    (en),
      .count (req_tdata),
      .days  (days),
      .rem   (rem)
   );

   // stages 4 to 8: year, month and day
   ecal_date u_date (
      .clock (clock),
      .en    (en),
      .days  (days),
      .year  (year),
      .month (month),
      .day   (day)
   );

   // stages 4 to 8: hour, minute and second
   ecal_clock u_clock (
      .clock  (clock),
      .en     (en),
      .rem    (rem),
      .hour   (hour),
      .minute (minute),
      .second (second)
   );

   assign req_tready = en;
   assign rsp_tvalid = valid_ff[Stages-1];
   assign rsp_tdata  = {2'b00, second, minute, hour, day, month, year};

   // a stall only comes from a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req side stalled with no result pending");

   // date fields stay in calendar range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31))
      else $error("month or day out of range");

   // year stays within the span of a 32-bit count
   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (year >= 12'd1970 && year <= 12'd2106))
      else $error("year out of range");

   // time of day fields stay in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
      else $error("time of day out of range");

endmodule

`default_nettype wire

@@ bench/calendar_checker.sv @@
`timescale 1ns / 1ps

module calendar_checker
   import ecal_pkg::*;
#(
   parameter int unsigned RspBits = 40
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [CountWidth-1:0] req_tdata,   // seconds_count
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RspBits-1:0]    rsp_tdata,   // year, month, day, hour, minute, second
   output int                         failures,
   output int                         outstanding
);

   localparam int unsigned SecondsPerDay    = 86400;
   localparam int unsigned SecondsPerHour   = 3600;
   localparam int unsigned SecondsPerMinute = 60;
   localparam int unsigned FirstYear        = 1970;
   localparam int unsigned DaysInYear       = 365;
   localparam int unsigned DaysInLeapYear   = 366;
   localparam int unsigned LeapFebruary     = 29;
   localparam int unsigned February         = 2;
   localparam int unsigned December         = 12;
   localparam int unsigned MonthDays [12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // year sits in the lowest bits, so it is declared last
   typedef struct packed {
      logic [SecondWidth-1:0] second;
      logic [MinuteWidth-1:0] minute;
      logic [HourWidth-1:0]   hour;
      logic [DayWidth-1:0]    day;
      logic [MonthWidth-1:0]  month;
      logic [YearWidth-1:0]   year;
   } calendar_stamp_type;

   calendar_stamp_type stamps_due [$];

   // gregorian rule: every 4th year, except centuries not divisible by 400
   function automatic bit leap_year(input int unsigned yr);
      return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
   endfunction

   function automatic int unsigned days_in_month(input int unsigned mo, input int unsigned yr);
      if (mo == February && leap_year(yr)) begin
         return LeapFebruary;
      end
      return MonthDays[mo-1];
   endfunction

   function automatic int unsigned days_in_year(input int unsigned yr);
      return leap_year(yr) ? DaysInLeapYear : DaysInYear;
   endfunction

   // strip whole years, then whole months, then split the time of day
   function automatic calendar_stamp_type to_calendar(input logic [CountWidth-1:0] count);
      int unsigned        days;
      int unsigned        secs_of_day;
      int unsigned        yr;
      int unsigned        mo;
      calendar_stamp_type stamp;
      days        = count / SecondsPerDay;
      secs_of_day = count % SecondsPerDay;
      yr          = FirstYear;
      mo          = 1;
      while (days >= days_in_year(yr)) begin
         days = days - days_in_year(yr);
         yr++;
      end
      while (mo < December && days >= days_in_month(mo, yr)) begin
         days = days - days_in_month(mo, yr);
         mo++;
      end
      stamp.year   = YearWidth'(yr);
      stamp.month  = MonthWidth'(mo);
      stamp.day    = DayWidth'(days + 1);
      stamp.hour   = HourWidth'(secs_of_day / SecondsPerHour);
      stamp.minute = MinuteWidth'((secs_of_day % SecondsPerHour) / SecondsPerMinute);
      stamp.second = SecondWidth'(secs_of_day % SecondsPerMinute);
      return stamp;
   endfunction

   task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // predict on each accepted item, compare on each accepted result
   always @(posedge clock) begin
      calendar_stamp_type want;
      calendar_stamp_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            stamps_due.push_back(to_calendar(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = calendar_stamp_type'(rsp_tdata[$bits(calendar_stamp_type)-1:0]);
            if (stamps_due.size() == 0) begin
               $error("result with no item pending: %h", rsp_tdata);
               failures++;
            end else begin
               want = stamps_due.pop_front();
               compare_field("year", want.year, got.year);
               compare_field("month", want.month, got.month);
               compare_field("day", want.day, got.day);
               compare_field("hour", want.hour, got.hour);
               compare_field("minute", want.minute, got.minute);
               compare_field("second", want.second, got.second);
            end
         end
         outstanding = stamps_due.size();
      end
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench
   import ecal_pkg::*;
();

   localparam int unsigned RspBits      = 40;
   localparam int unsigned RandomItems  = 1800;
   localparam int unsigned CalmFirst    = 700;
   localparam int unsigned CalmLast     = 1000;
   localparam int unsigned IdlePercent  = 37;
   localparam int unsigned DrainCycles  = 24;
   localparam int unsigned LastDay      = 49710;
   localparam int unsigned SecondsPerDay = 86400;
   localparam int unsigned WatchdogNs   = 2000000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CountWidth-1:0] req_tdata  = '0;    // seconds_count
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RspBits-1:0]    rsp_tdata;          // year, month, day, hour, minute, second
   logic                  calm       = 1'b0;
   int                    failures;
   int                    outstanding;

   always #2 clock = ~clock;

   epoch_seconds_to_calendar dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   calendar_checker #(.RspBits(RspBits)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // receiver back-pressure, switched off during the calm stretch
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= IdlePercent);
   end

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_count(input logic [CountWidth-1:0] count);
      while (!calm && $urandom_range(0, 99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= count;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      #WatchdogNs;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [CountWidth-1:0] landmarks [$];
      longint unsigned       pick;
      int unsigned           days;
      landmarks = '{
         32'd0,            // epoch start
         32'd1,
         32'd86399,        // last second of the first day
         32'd86400,        // first second of day two
         32'd2678399,      // end of january 1970
         32'd2678400,      // start of february 1970
         32'd68169600,     // leap day 1972
         32'd94694399,     // last second of a leap year
         32'd94694400,
         32'd951782400,    // leap day of a 400 year
         32'd951868800,
         32'd2147483647,
         32'd2147483648,
         32'd4107542399,   // end of february in a century non-leap year
         32'd4107542400,
         32'd4291747200,   // start of the last year
         32'hAAAAAAAA,
         32'h55555555,
         32'hFFFFFFFE,
         32'hFFFFFFFF      // largest count
      };

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed landmarks
      foreach (landmarks[i]) begin
         send_count(landmarks[i]);
      end

      // random mix: uniform, near midnight, first 400 days
      for (int n = 0; n < RandomItems; n++) begin
         calm = (n >= CalmFirst && n < CalmLast);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: pick = $urandom;
            4, 5, 6, 7: begin
               days = $urandom_range(0, LastDay);
               case ($urandom_range(0, 3))
                  0: pick = longint'(days) * SecondsPerDay;
                  1: pick = longint'(days) * SecondsPerDay + 1;
                  2: pick = longint'(days) * SecondsPerDay + SecondsPerDay - 2;
                  default: pick = longint'(days) * SecondsPerDay + SecondsPerDay - 1;
               endcase
               if (pick > 64'hFFFFFFFF) pick = 64'hFFFFFFFF;
            end
            default: pick = $urandom_range(0, 400 * SecondsPerDay);
         endcase
         send_count(CountWidth'(pick));
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain the pipeline, then watch for stray results
      while (outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
